// ----- design/vwl_pkg.sv -----
// Shared types, codes and sizing constants for the vertex weld block.
package vwl_pkg;

  localparam int MaxVertices    = 256;
  localparam int MaxLoopDef     = 32;
  localparam int CoordBitsDef   = 24;
  localparam int TolBits        = 24;
  localparam int IdxBits        = 8;

  typedef enum logic [1:0] {
    OP_VERTEX = 2'd0,
    OP_LOOP   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_UNKNOWN  = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  // one result word toward the output register
  typedef struct packed {
    logic [IdxBits-1:0] idx;
    logic               is_new;
    logic               last;
    status_t            status;
  } res_t;

endpackage

// ----- design/vertex_weld_and_loop_remap.sv -----
// Top level of the vertex weld and face-loop remap block.
//   channel | dir | tdata                                      | tuser | tlast
//   in_     | in  | pos_x,pos_y,pos_z,vertex_index (80b)       | op    | loop_end
//   out_    | out | result_index,is_new,status (16b)           | -     | last_of_run
//   cfg_    | in  | weld_tolerance (24b)                       | -     | -
// A vertex has its result after a scan of the kept vertices: one kept-vertex memory
// read per cycle feeding the distance compare; a hit ends the scan early. A loop element
// is stored in the loop buffer; a closing element then reads the buffer back and emits
// the remapped indices, skipping repeats. rst_n is synchronous and clears the counts, state,
// result valid and tolerance, not the memories. Input is held off while a result waits on out_tready.
module vertex_weld_and_loop_remap import vwl_pkg::*; #(
  parameter int MAX_LOOP     = MaxLoopDef,
  parameter int COORD_BITS   = CoordBitsDef
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [TolBits-1:0]        cfg_wdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [3*COORD_BITS+7:0]   in_tdata,  // pos_x, pos_y, pos_z, vertex_index
  input  logic [1:0]                in_tuser,  // op
  input  logic                      in_tlast,  // loop_end
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [15:0]               out_tdata,  // result_index, is_new, status
  output logic                      out_tlast   // last_of_run
);
  logic [TolBits-1:0] tol_r;
  res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= '0;
    else if (cfg_we) tol_r <= cfg_wdata;
  end

  vwl_ctrl #(.MAX_LOOP(MAX_LOOP), .COORD_BITS(COORD_BITS)) u_ctrl (
    .clk (clk), .rst_n (rst_n), .tol (tol_r),
    .in_valid (in_tvalid), .in_ready (in_tready),
    .op (op_t'(in_tuser)),
    .px (in_tdata[COORD_BITS-1:0]),
    .py (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .pz (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .vidx (in_tdata[3*COORD_BITS+7:3*COORD_BITS]),
    .lend (in_tlast),
    .res_valid (out_tvalid), .res_ready (out_tready), .res (res)
  );

  assign out_tdata = {4'd0, res.status, res.is_new, res.idx};
  assign out_tlast = res.last;
endmodule

// ----- design/vwl_dist.sv -----
// Registered tolerance test of one kept vertex against the incoming vertex.
module vwl_dist import vwl_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                         clk,
  input  logic [TolBits-1:0]           tol,
  input  logic signed [COORD_BITS-1:0] ax, ay, az,
  input  logic signed [COORD_BITS-1:0] bx, by, bz,
  input  logic                         go,
  output logic                         done,
  output logic                         hit
);
  localparam int DW = COORD_BITS + 1;
  localparam int MW = (DW > TolBits ? DW : TolBits);
  localparam int SW = 2 * MW + 2;

  logic [DW-1:0] dx, dy, dz;
  logic [MW-1:0] dx_r, dy_r, dz_r, t_r;
  logic          over_r, go1_r, go2_r;
  logic [2*MW-1:0] sx_r, sy_r, sz_r, tt_r;
  logic          over2_r;
  logic [SW-1:0] sum;

  function automatic logic [DW-1:0] absd(logic signed [COORD_BITS-1:0] a,
                                         logic signed [COORD_BITS-1:0] b);
    logic signed [DW-1:0] d;
    d = DW'(a) - DW'(b);
    return d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  always_comb begin
    dx = absd(ax, bx);
    dy = absd(ay, by);
    dz = absd(az, bz);
  end

  // stage 1: differences, per-axis early reject
  always_ff @(posedge clk) begin
    dx_r   <= MW'(dx);
    dy_r   <= MW'(dy);
    dz_r   <= MW'(dz);
    t_r    <= MW'(tol);
    over_r <= (MW'(dx) > MW'(tol)) || (MW'(dy) > MW'(tol)) || (MW'(dz) > MW'(tol));
    go1_r  <= go;
  end

  // stage 2: squares
  always_ff @(posedge clk) begin
    sx_r    <= dx_r * dx_r;
    sy_r    <= dy_r * dy_r;
    sz_r    <= dz_r * dz_r;
    tt_r    <= t_r * t_r;
    over2_r <= over_r;
    go2_r   <= go1_r;
  end

  assign sum  = SW'(sx_r) + SW'(sy_r) + SW'(sz_r);
  assign done = go2_r;
  assign hit  = !over2_r && (sum <= SW'(tt_r));
endmodule

// ----- design/vwl_ctrl.sv -----
// Sequencer over the kept-vertex, index-map and loop memories.
module vwl_ctrl import vwl_pkg::*; #(
  parameter int MAX_LOOP     = MaxLoopDef,
  parameter int COORD_BITS   = CoordBitsDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [TolBits-1:0]    tol,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  op_t                   op,
  input  logic [COORD_BITS-1:0] px, py, pz,
  input  logic [IdxBits-1:0]    vidx,
  input  logic                  lend,
  output logic                  res_valid,
  input  logic                  res_ready,
  output res_t                  res
);
  localparam int MAX_VERTICES = MaxVertices;
  localparam int VA = $clog2(MAX_VERTICES);
  localparam int VC = VA + 1;
  localparam int LA = $clog2(MAX_LOOP);
  localparam int LC = LA + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_DECIDE, S_MAP, S_LRD, S_EMIT,
    S_LOUT, S_LSTEP, S_PUT
  } state_t;

  state_t state_r;
  logic [COORD_BITS-1:0] kx_mem [MAX_VERTICES];
  logic [COORD_BITS-1:0] ky_mem [MAX_VERTICES];
  logic [COORD_BITS-1:0] kz_mem [MAX_VERTICES];
  logic [IdxBits-1:0]    map_mem [MAX_VERTICES];
  logic [IdxBits-1:0]    lbuf_mem [MAX_LOOP];

  logic [COORD_BITS-1:0] kx_q, ky_q, kz_q, vx_r, vy_r, vz_r;
  logic [IdxBits-1:0]    map_q, lb_q, lb2_q;
  logic [VC-1:0] kept_r, vcnt_r, scan_r, hitj_r;
  logic          found_r, rd_go_r, in_flight_r;
  logic [LC-1:0] llen_r, n_r, i_r;
  logic          lend_r;
  logic [IdxBits-1:0] last_r, pend_r;
  logic          pend_ok_r;
  logic          dist_done, dist_hit;
  logic [VC-1:0] hit_pipe1_r, hit_pipe2_r;
  res_t          res_r;
  logic          res_v_r;

  logic          k_rd;
  logic [VA-1:0] k_ra;
  logic          l_rd;
  logic [LA-1:0] l_ra;

  // kept vertex memory, one read port
  always_ff @(posedge clk) begin
    if (state_r == S_DECIDE && !found_r && kept_r < VC'(MAX_VERTICES)) begin
      kx_mem[kept_r[VA-1:0]] <= vx_r;
      ky_mem[kept_r[VA-1:0]] <= vy_r;
      kz_mem[kept_r[VA-1:0]] <= vz_r;
    end
    if (k_rd) begin
      kx_q <= kx_mem[k_ra];
      ky_q <= ky_mem[k_ra];
      kz_q <= kz_mem[k_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DECIDE && (found_r || kept_r < VC'(MAX_VERTICES)))
      map_mem[vcnt_r[VA-1:0]] <= found_r ? IdxBits'(hitj_r) : IdxBits'(kept_r);
    if (in_valid && in_ready)
      map_q <= map_mem[vidx[VA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PUT)
      lbuf_mem[llen_r[LA-1:0]] <= map_q;
    if (l_rd)
      lb_q <= lbuf_mem[l_ra];
  end

  assign k_rd = (state_r == S_SCAN);
  assign k_ra = scan_r[VA-1:0];
  assign l_rd = 1'b1;
  assign l_ra = (state_r == S_LRD) ? LA'(n_r - LC'(1)) : i_r[LA-1:0];

  vwl_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk (clk), .tol (tol),
    .ax (kx_q), .ay (ky_q), .az (kz_q),
    .bx (vx_r), .by (vy_r), .bz (vz_r),
    .go (rd_go_r), .done (dist_done), .hit (dist_hit)
  );

  assign in_ready  = (state_r == S_IDLE) && !res_v_r;
  assign res_valid = res_v_r;
  assign res       = res_r;
  assign lb2_q     = lb_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kept_r <= '0; vcnt_r <= '0; llen_r <= '0;
      res_v_r <= 1'b0; rd_go_r <= 1'b0; found_r <= 1'b0;
      in_flight_r <= 1'b0;
    end else begin
      if (res_v_r && res_ready) res_v_r <= 1'b0;
      rd_go_r     <= 1'b0;
      // scan_r already points past the entry whose read went out last cycle
      hit_pipe1_r <= scan_r - VC'(1);
      hit_pipe2_r <= hit_pipe1_r;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            vx_r <= px; vy_r <= py; vz_r <= pz;
            lend_r <= lend;
            unique case (op)
              OP_VERTEX: begin
                if (vcnt_r >= VC'(MAX_VERTICES)) begin
                  res_r   <= '{idx: '0, is_new: 1'b0, last: 1'b1, status: ST_FULL};
                  res_v_r <= 1'b1;
                end else begin
                  scan_r  <= '0;
                  found_r <= 1'b0;
                  state_r <= S_SCAN;
                end
              end
              OP_LOOP: begin
                if (VC'(vidx) >= vcnt_r || llen_r >= LC'(MAX_LOOP)) begin
                  res_r <= '{idx: '0, is_new: 1'b0, last: 1'b1,
                             status: (VC'(vidx) >= vcnt_r) ? ST_UNKNOWN : ST_TOO_LONG};
                  res_v_r <= 1'b1;
                  if (lend) llen_r <= '0;
                end else begin
                  state_r <= S_PUT;
                end
              end
              OP_CLEAR: begin
                kept_r <= '0; vcnt_r <= '0; llen_r <= '0;
              end
              default: ;
            endcase
          end
        end
        // issue one read a cycle; hits come back through the read register and the compare stages
        S_SCAN: begin
          if (dist_done && dist_hit && !found_r) begin
            found_r <= 1'b1; hitj_r <= hit_pipe2_r;
          end
          if (scan_r < kept_r && !(dist_done && dist_hit) && !found_r) begin
            rd_go_r <= 1'b1;
            scan_r  <= scan_r + VC'(1);
          end else begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (dist_done && dist_hit && !found_r) begin
            found_r <= 1'b1; hitj_r <= hit_pipe2_r;
          end
          if (!rd_go_r && !dist_done && !in_flight_r) state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (found_r) begin
            res_r  <= '{idx: IdxBits'(hitj_r), is_new: 1'b0, last: 1'b1, status: ST_OK};
            vcnt_r <= vcnt_r + VC'(1);
          end else if (kept_r >= VC'(MAX_VERTICES)) begin
            res_r  <= '{idx: '0, is_new: 1'b0, last: 1'b1, status: ST_FULL};
          end else begin
            res_r  <= '{idx: IdxBits'(kept_r), is_new: 1'b1, last: 1'b1, status: ST_OK};
            kept_r <= kept_r + VC'(1);
            vcnt_r <= vcnt_r + VC'(1);
          end
          res_v_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_PUT: begin
          llen_r <= llen_r + LC'(1);
          if (lend_r) begin
            n_r <= llen_r + LC'(1);
            llen_r <= '0;
            state_r <= S_LRD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_LRD: state_r <= S_MAP;
        // last element becomes the cyclic predecessor of the first
        S_MAP: begin
          last_r  <= lb_q;
          i_r     <= '0;
          pend_ok_r <= 1'b0;
          state_r <= S_EMIT;
        end
        S_EMIT: state_r <= S_LSTEP;
        S_LSTEP: begin
          if (n_r == LC'(1)) begin
            res_r   <= '{idx: lb2_q, is_new: 1'b0, last: 1'b1, status: ST_OK};
            res_v_r <= 1'b1;
            state_r <= S_IDLE;
          end else if (lb2_q != last_r) begin
            // hold one result back so its last flag is known
            if (pend_ok_r) begin
              if (!res_v_r || res_ready) begin
                res_r   <= '{idx: pend_r, is_new: 1'b0, last: 1'b0, status: ST_OK};
                res_v_r <= 1'b1;
                pend_r  <= lb2_q;
                last_r  <= lb2_q;
                state_r <= S_LOUT;
              end
            end else begin
              pend_r <= lb2_q; pend_ok_r <= 1'b1; last_r <= lb2_q;
              state_r <= S_LOUT;
            end
          end else begin
            state_r <= S_LOUT;
          end
        end
        S_LOUT: begin
          if (i_r + LC'(1) < n_r) begin
            i_r     <= i_r + LC'(1);
            state_r <= S_EMIT;
          end else if (!res_v_r || res_ready) begin
            res_r <= pend_ok_r
                   ? '{idx: pend_r, is_new: 1'b0, last: 1'b1, status: ST_OK}
                   : '{idx: '0, is_new: 1'b0, last: 1'b1, status: ST_EMPTY};
            res_v_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      in_flight_r <= rd_go_r;
    end
  end
endmodule
